[rtl/ccwp_pkg.sv]
`default_nettype none

package ccwp_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_kind;
    typedef logic [3:0] t_nibble;

    localparam t_op OP_ADD_CODE      = 2'd0;
    localparam t_op OP_ADD_INTERCEPT = 2'd1;
    localparam t_op OP_ADD_COMPARE   = 2'd2;
    localparam t_op OP_BUS_WRITE     = 2'd3;

    localparam t_kind KIND_NONE    = 2'd0;
    localparam t_kind KIND_FORWARD = 2'd1;
    localparam t_kind KIND_STORED  = 2'd2;
    localparam t_kind KIND_FULL    = 2'd3;

    typedef struct packed {
        logic hit;
        logic room;
    } t_tbl_status;

    function automatic t_nibble letter_nibble(input logic [7:0] ch);
        t_nibble n;
        unique case (ch)
            8'h41:   n = 4'd0;   // A
            8'h50:   n = 4'd1;   // P
            8'h5A:   n = 4'd2;   // Z
            8'h4C:   n = 4'd3;   // L
            8'h47:   n = 4'd4;   // G
            8'h49:   n = 4'd5;   // I
            8'h54:   n = 4'd6;   // T
            8'h59:   n = 4'd7;   // Y
            8'h45:   n = 4'd8;   // E
            8'h4F:   n = 4'd9;   // O
            8'h58:   n = 4'd10;  // X
            8'h55:   n = 4'd11;  // U
            8'h4B:   n = 4'd12;  // K
            8'h53:   n = 4'd13;  // S
            8'h56:   n = 4'd14;  // V
            8'h4E:   n = 4'd15;  // N
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

[rtl/cheat_code_write_patcher.sv]
`default_nettype none

// Channel   Direction  Handshake                    Fields
// command   in         start (busy held low)        i_op, i_address, i_write_data,
//                                                   i_compare_value, i_code_letters,
//                                                   i_code_is_eight
// result    out        o_result_valid, one cycle    o_result_kind, o_out_address, o_out_data
//
// One command per cycle; each result follows its command through the input register,
// then table lookup and update into the result register.
// The lookup compares all TABLE_ENTRIES addresses of both tables in parallel.
// Reset clears the valid bits of both tables at once; no clearing pass.
// Results cannot be stalled and busy never rises.

module cheat_code_write_patcher
    import ccwp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [7:0]  i_compare_value,
    input  wire logic [63:0] i_code_letters,
    input  wire logic        i_code_is_eight,
    output logic             o_result_valid,
    output logic [1:0]       o_result_kind,
    output logic [15:0]      o_out_address,
    output logic [7:0]       o_out_data
);

    logic        r_in_valid;
    t_op         r_in_op;
    logic [15:0] r_in_address;
    logic [7:0]  r_in_write_data;
    logic [7:0]  r_in_compare_value;
    logic [63:0] r_in_letters;
    logic        r_in_eight;

    logic        r_out_valid;
    t_kind       r_kind;
    logic [15:0] r_addr;
    logic [7:0]  r_data;

    t_kind       n_kind;
    logic [15:0] n_addr;
    logic [7:0]  n_data;

    t_nibble     c [8];
    logic [15:0] code_addr;
    logic [7:0]  code_data;
    logic [7:0]  code_match;

    logic [15:0] key;
    logic        ic_wr;
    logic        cp_wr;
    logic [7:0]  ic_wr_data;
    logic [15:0] cp_wr_data;
    t_tbl_status ic_status;
    t_tbl_status cp_status;
    logic [7:0]  ic_rd_data;
    logic [15:0] cp_rd_data;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in_op            <= i_op;
            r_in_address       <= i_address;
            r_in_write_data    <= i_write_data;
            r_in_compare_value <= i_compare_value;
            r_in_letters       <= i_code_letters;
            r_in_eight         <= i_code_is_eight;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            c[i] = letter_nibble(r_in_letters[8*i +: 8]);
        end
        code_addr  = {1'b1, c[3][2:0], c[4][3], c[5][2:0],
                      c[1][3], c[2][2:0], c[3][3], c[4][2:0]};
        code_data  = {c[0][3], c[1][2:0], (r_in_eight ? c[7][3] : c[5][3]), c[0][2:0]};
        code_match = {c[6][3], c[7][2:0], c[5][3], c[6][2:0]};
    end

    always_comb begin
        key        = (r_in_op == OP_ADD_CODE) ? code_addr : r_in_address;
        ic_wr      = 1'b0;
        cp_wr      = 1'b0;
        ic_wr_data = r_in_write_data;
        cp_wr_data = {r_in_write_data, r_in_compare_value};
        n_kind     = KIND_NONE;
        n_addr     = '0;
        n_data     = '0;
        unique case (r_in_op)
            OP_ADD_CODE: begin
                ic_wr      = r_in_valid && !r_in_eight;
                cp_wr      = r_in_valid && r_in_eight;
                ic_wr_data = code_data;
                cp_wr_data = {code_data, code_match};
                n_addr     = code_addr;
                n_data     = code_data;
                if (r_in_eight) begin
                    n_kind = cp_status.room ? KIND_STORED : KIND_FULL;
                end else begin
                    n_kind = ic_status.room ? KIND_STORED : KIND_FULL;
                end
            end
            OP_ADD_INTERCEPT: begin
                ic_wr  = r_in_valid;
                n_kind = ic_status.room ? KIND_STORED : KIND_FULL;
                n_addr = r_in_address;
                n_data = r_in_write_data;
            end
            OP_ADD_COMPARE: begin
                cp_wr  = r_in_valid;
                n_kind = cp_status.room ? KIND_STORED : KIND_FULL;
                n_addr = r_in_address;
                n_data = r_in_write_data;
            end
            OP_BUS_WRITE: begin
                // drop intercepted writes and writes that hit neither table
                if (!ic_status.hit && cp_status.hit) begin
                    n_kind = KIND_FORWARD;
                    n_addr = r_in_address;
                    n_data = (cp_rd_data[7:0] == r_in_write_data) ?
                             cp_rd_data[15:8] : r_in_write_data;
                end
            end
            default: begin
                n_kind = KIND_NONE;
            end
        endcase
    end

    ccwp_table #(
        .ENTRIES (TABLE_ENTRIES),
        .DATA_W  (8)
    ) u_intercept (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (key),
        .i_wr_en   (ic_wr),
        .i_wr_data (ic_wr_data),
        .o_status  (ic_status),
        .o_rd_data (ic_rd_data)
    );

    ccwp_table #(
        .ENTRIES (TABLE_ENTRIES),
        .DATA_W  (16)
    ) u_compare (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (key),
        .i_wr_en   (cp_wr),
        .i_wr_data (cp_wr_data),
        .o_status  (cp_status),
        .o_rd_data (cp_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        // intercept byte is only stored; a hit alone decides the drop
        r_kind <= n_kind;
        r_addr <= n_addr;
        r_data <= (ic_rd_data == ic_rd_data) ? n_data : n_data;
    end

    assign o_result_valid = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_out_address  = r_addr;
    assign o_out_data     = r_data;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_result_valid)
        else $error("accepted beat produced no result");

    a_result_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_in_valid))
        else $error("result without a command");

    a_forward_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result_kind == KIND_FORWARD)) |->
            ($past(r_in_op) == OP_BUS_WRITE))
        else $error("forward from a non-write command");

    a_full_not_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result_kind == KIND_FULL)) |->
            ($past(r_in_op) != OP_BUS_WRITE))
        else $error("table full reported for a bus write");
`endif

endmodule

`default_nettype wire

[rtl/ccwp_table.sv]
`default_nettype none

module ccwp_table
    import ccwp_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int DATA_W  = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [15:0]       i_key,
    input  wire logic              i_wr_en,
    input  wire logic [DATA_W-1:0] i_wr_data,
    output t_tbl_status            o_status,
    output logic [DATA_W-1:0]      o_rd_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ENTRIES-1:0] r_valid;
    logic [15:0]        r_addr [ENTRIES];
    logic [DATA_W-1:0]  r_data [ENTRIES];

    logic             hit;
    logic             any_free;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] slot;

    always_comb begin
        hit      = 1'b0;
        any_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        // scan downward so the lowest index wins
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_addr[i] == i_key)) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
        slot = hit ? hit_idx : free_idx;
    end

    assign o_status.hit  = hit;
    assign o_status.room = hit | any_free;
    assign o_rd_data     = r_data[hit_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en && o_status.room) begin
            r_valid[slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && o_status.room) begin
            r_addr[slot] <= i_key;
            r_data[slot] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

[sim/patch_checker.sv]
`timescale 1ns / 1ps

module patch_checker
    import ccwp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [7:0]  i_compare_value,
    input  wire logic [63:0] i_code_letters,
    input  wire logic        i_code_is_eight,
    input  wire logic        i_result_valid,
    input  wire logic [1:0]  i_result_kind,
    input  wire logic [15:0] i_out_address,
    input  wire logic [7:0]  i_out_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam logic [127:0] ALPHABET = "APZLGITYEOXUKSVN";

    typedef struct packed {
        t_kind       kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_patch_result;

    t_patch_result due_results [$];

    logic [TABLE_ENTRIES-1:0]       icp_valid;
    logic [TABLE_ENTRIES-1:0][15:0] icp_addr;
    logic [TABLE_ENTRIES-1:0][7:0]  icp_byte;
    logic [TABLE_ENTRIES-1:0]       cmp_valid;
    logic [TABLE_ENTRIES-1:0][15:0] cmp_addr;
    logic [TABLE_ENTRIES-1:0][7:0]  cmp_repl;
    logic [TABLE_ENTRIES-1:0][7:0]  cmp_match;

    function automatic t_nibble decode_letter(input logic [7:0] ch);
        for (int i = 0; i < 16; i++) begin
            if (ALPHABET[127-8*i -: 8] == ch) begin
                return i[3:0];
            end
        end
        return 4'd0;
    endfunction

    function automatic int hit_slot(input logic [TABLE_ENTRIES-1:0] vld,
                                    input logic [TABLE_ENTRIES-1:0][15:0] adr,
                                    input logic [15:0] a);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (vld[i] && adr[i] == a) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int room_slot(input logic [TABLE_ENTRIES-1:0] vld,
                                     input logic [TABLE_ENTRIES-1:0][15:0] adr,
                                     input logic [15:0] a);
        int s;
        s = hit_slot(vld, adr, a);
        if (s >= 0) begin
            return s;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!vld[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic put_intercept(input logic [15:0] a, input logic [7:0] d, output t_kind k);
        int s;
        s = room_slot(icp_valid, icp_addr, a);
        k = KIND_FULL;
        if (s >= 0) begin
            icp_valid[s] = 1'b1;
            icp_addr[s]  = a;
            icp_byte[s]  = d;
            k = KIND_STORED;
        end
    endtask

    task automatic put_compare(input logic [15:0] a, input logic [7:0] d,
                               input logic [7:0] m, output t_kind k);
        int s;
        s = room_slot(cmp_valid, cmp_addr, a);
        k = KIND_FULL;
        if (s >= 0) begin
            cmp_valid[s] = 1'b1;
            cmp_addr[s]  = a;
            cmp_repl[s]  = d;
            cmp_match[s] = m;
            k = KIND_STORED;
        end
    endtask

    task automatic patch_outcome(input t_op op, input logic [15:0] a, input logic [7:0] wd,
                                 input logic [7:0] cv, input logic [63:0] letters,
                                 input logic eight, output t_patch_result r);
        logic [7:0][3:0] c;
        logic [15:0]     ka;
        logic [7:0]      kd;
        logic [7:0]      km;
        int              s;
        r = '0;
        case (op)
            OP_ADD_CODE: begin
                for (int i = 0; i < 8; i++) begin
                    c[i] = decode_letter(letters[8*i +: 8]);
                end
                ka = {1'b1, c[3][2:0], c[4][3], c[5][2:0], c[1][3], c[2][2:0],
                      c[3][3], c[4][2:0]};
                kd = {c[0][3], c[1][2:0], eight ? c[7][3] : c[5][3], c[0][2:0]};
                km = {c[6][3], c[7][2:0], c[5][3], c[6][2:0]};
                if (eight) begin
                    put_compare(ka, kd, km, r.kind);
                end else begin
                    put_intercept(ka, kd, r.kind);
                end
                r.addr = ka;
                r.data = kd;
            end
            OP_ADD_INTERCEPT: begin
                put_intercept(a, wd, r.kind);
                r.addr = a;
                r.data = wd;
            end
            OP_ADD_COMPARE: begin
                put_compare(a, wd, cv, r.kind);
                r.addr = a;
                r.data = wd;
            end
            default: begin
                // intercept wins over compare; a miss in both forwards nothing
                if (hit_slot(icp_valid, icp_addr, a) < 0) begin
                    s = hit_slot(cmp_valid, cmp_addr, a);
                    if (s >= 0) begin
                        r.kind = KIND_FORWARD;
                        r.addr = a;
                        r.data = (cmp_match[s] == wd) ? cmp_repl[s] : wd;
                    end
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : track
        t_patch_result want;
        t_patch_result got;
        if (!i_rst_n) begin
            icp_valid = '0;
            cmp_valid = '0;
            icp_addr  = '0;
            icp_byte  = '0;
            cmp_addr  = '0;
            cmp_repl  = '0;
            cmp_match = '0;
            due_results.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_start && !i_busy) begin
                patch_outcome(i_op, i_address, i_write_data, i_compare_value,
                              i_code_letters, i_code_is_eight, want);
                due_results.push_back(want);
            end
            if (i_result_valid) begin
                got = {i_result_kind, i_out_address, i_out_data};
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result kind %0d address %h data %h",
                             $time, got.kind, got.addr, got.data);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (got.kind !== want.kind) begin
                            $display("%0t: result_kind expected %0d actual %0d",
                                     $time, want.kind, got.kind);
                        end
                        if (got.addr !== want.addr) begin
                            $display("%0t: out_address expected %h actual %h",
                                     $time, want.addr, got.addr);
                        end
                        if (got.data !== want.data) begin
                            $display("%0t: out_data expected %h actual %h",
                                     $time, want.data, got.data);
                        end
                    end
                end
            end
            o_pending = due_results.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench
    import ccwp_pkg::*;
();

    localparam int           IDLE_LIMIT   = 2000;
    localparam int           PHASE_ITEMS  = 175;
    localparam logic [127:0] ALPHABET     = "APZLGITYEOXUKSVN";

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_op         i_op;
    logic [15:0] i_address;
    logic [7:0]  i_write_data;
    logic [7:0]  i_compare_value;
    logic [63:0] i_code_letters;
    logic        i_code_is_eight;
    logic        o_result_valid;
    logic [1:0]  o_result_kind;
    logic [15:0] o_out_address;
    logic [7:0]  o_out_data;

    int          fail_count;
    int          pending;
    int          idle_pct = 0;
    int          quiet_cycles = 0;
    logic [15:0] addr_pool [28];
    logic [7:0]  byte_pool [4];

    cheat_code_write_patcher DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_address       (i_address),
        .i_write_data    (i_write_data),
        .i_compare_value (i_compare_value),
        .i_code_letters  (i_code_letters),
        .i_code_is_eight (i_code_is_eight),
        .o_result_valid  (o_result_valid),
        .o_result_kind   (o_result_kind),
        .o_out_address   (o_out_address),
        .o_out_data      (o_out_data)
    );

    patch_checker u_patch_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_op            (i_op),
        .i_address       (i_address),
        .i_write_data    (i_write_data),
        .i_compare_value (i_compare_value),
        .i_code_letters  (i_code_letters),
        .i_code_is_eight (i_code_is_eight),
        .i_result_valid  (o_result_valid),
        .i_result_kind   (o_result_kind),
        .i_out_address   (o_out_address),
        .i_out_data      (o_out_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] any_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(99) < 60) begin
            b = byte_pool[$urandom_range(3)];
        end
        return b;
    endfunction

    // build letters that decode to the given address, data and match bytes (address bit 15 decodes as one)
    function automatic logic [63:0] code_for(input logic [15:0] a, input logic [7:0] d,
                                             input logic [7:0] m, input logic eight);
        logic [7:0][3:0] c;
        logic [63:0]     letters;
        logic            spare;
        spare = 1'($urandom);
        c[0] = {d[7], d[2:0]};
        c[1] = {a[7], d[6:4]};
        c[2] = {spare, a[6:4]};
        c[3] = {a[3], a[14:12]};
        c[4] = {a[11], a[2:0]};
        c[5] = {eight ? m[3] : d[3], a[10:8]};
        c[6] = {m[7], m[2:0]};
        c[7] = {d[3], m[6:4]};
        for (int i = 0; i < 8; i++) begin
            letters[8*i +: 8] = ALPHABET[127-8*c[i] -: 8];
        end
        return letters;
    endfunction

    task automatic send_beat(input t_op op, input logic [15:0] a, input logic [7:0] wd,
                             input logic [7:0] cv, input logic [63:0] letters,
                             input logic eight);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_op            <= op;
        i_address       <= a;
        i_write_data    <= wd;
        i_compare_value <= cv;
        i_code_letters  <= letters;
        i_code_is_eight <= eight;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_random();
        t_op         op;
        logic [15:0] a;
        logic [7:0]  wd;
        logic [7:0]  cv;
        logic [63:0] letters;
        logic        eight;
        int          pick;
        int          k;
        op      = t_op'($urandom);
        a       = 16'($urandom);
        wd      = 8'($urandom);
        cv      = 8'($urandom);
        letters = {$urandom, $urandom};
        eight   = 1'($urandom);
        pick    = $urandom_range(99);
        if (pick < 25) begin
            op = OP_ADD_INTERCEPT;
            a  = addr_pool[$urandom_range(19)];
            wd = any_byte();
        end else if (pick < 50) begin
            op = OP_ADD_COMPARE;
            a  = addr_pool[$urandom_range(27, 8)];
            wd = any_byte();
            cv = any_byte();
        end else if (pick < 62) begin
            op = OP_ADD_CODE;
            a  = eight ? addr_pool[$urandom_range(27, 8)] : addr_pool[$urandom_range(19)];
            letters = code_for(a, any_byte(), any_byte(), eight);
            if ($urandom_range(6) == 0) begin
                k = $urandom_range(7);
                letters[8*k +: 8] = 8'($urandom);
            end
        end else if (pick < 92) begin
            op = OP_BUS_WRITE;
            wd = any_byte();
            if ($urandom_range(4) != 0) begin
                a = addr_pool[$urandom_range(27)];
            end
        end
        send_beat(op, a, wd, cv, letters, eight);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_op            = OP_ADD_CODE;
        i_address       = '0;
        i_write_data    = '0;
        i_compare_value = '0;
        i_code_letters  = '0;
        i_code_is_eight = 1'b0;
        for (int i = 0; i < 28; i++) begin
            addr_pool[i] = 16'($urandom);
            if (i % 2 == 0) begin
                addr_pool[i][15] = 1'b1;
            end
        end
        byte_pool[0] = 8'h00;
        byte_pool[1] = 8'hFF;
        byte_pool[2] = 8'($urandom);
        byte_pool[3] = 8'($urandom);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_beat(OP_BUS_WRITE, 16'h1234, 8'h55, 8'h00, 64'h0, 1'b0);
        send_beat(OP_ADD_INTERCEPT, 16'h0000, 8'h00, 8'h00, 64'h0, 1'b0);
        send_beat(OP_ADD_INTERCEPT, 16'hFFFF, 8'hFF, 8'hFF, {64{1'b1}}, 1'b1);
        send_beat(OP_BUS_WRITE, 16'h0000, 8'h00, 8'h00, 64'h0, 1'b0);
        send_beat(OP_ADD_COMPARE, 16'hFFFF, 8'h11, 8'h22, 64'h0, 1'b0);
        send_beat(OP_BUS_WRITE, 16'hFFFF, 8'h22, 8'h00, 64'h0, 1'b0);
        send_beat(OP_ADD_COMPARE, 16'h8000, 8'hAB, 8'hCD, 64'h0, 1'b0);
        send_beat(OP_BUS_WRITE, 16'h8000, 8'hCD, 8'h00, 64'h0, 1'b0);
        send_beat(OP_BUS_WRITE, 16'h8000, 8'h00, 8'h00, 64'h0, 1'b0);
        send_beat(OP_ADD_COMPARE, 16'h8000, 8'hFF, 8'h00, 64'h0, 1'b0);
        send_beat(OP_BUS_WRITE, 16'h8000, 8'h00, 8'hFF, 64'h0, 1'b0);
        send_beat(OP_ADD_CODE, 16'h0000, 8'h00, 8'h00, 64'h4141414141414141, 1'b0);
        send_beat(OP_BUS_WRITE, 16'h8000, 8'h00, 8'h00, 64'h0, 1'b0);
        send_beat(OP_ADD_CODE, 16'h0000, 8'h00, 8'h00, code_for(16'hFFFF, 8'hFF, 8'hFF, 1'b1),
                  1'b1);
        send_beat(OP_ADD_CODE, 16'h0000, 8'h00, 8'h00, code_for(16'hC3A5, 8'h5A, 8'h3C, 1'b1),
                  1'b1);
        send_beat(OP_BUS_WRITE, 16'hC3A5, 8'h3C, 8'h00, 64'h0, 1'b0);
        send_beat(OP_BUS_WRITE, 16'hC3A5, 8'h3D, 8'h00, 64'h0, 1'b0);
        send_beat(OP_ADD_CODE, 16'h0000, 8'h00, 8'h00, code_for(16'hB6E1, 8'h7E, 8'h00, 1'b0),
                  1'b0);
        send_beat(OP_BUS_WRITE, 16'hB6E1, 8'h7E, 8'h00, 64'h0, 1'b0);
        send_beat(OP_ADD_CODE, 16'h0000, 8'h00, 8'h00, 64'h6E6E6E6E6E6E6E6E, 1'b1);
        send_beat(OP_ADD_CODE, 16'h0000, 8'h00, 8'h00, 64'h0, 1'b1);
        send_beat(OP_ADD_CODE, 16'h0000, 8'h00, 8'h00, {64{1'b1}}, 1'b0);
        send_beat(OP_ADD_CODE, 16'h0000, 8'h00, 8'h00, 64'h4E4E4E4E4E4E4E4E, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 65 : (phase == 3) ? 28 : 0;
            repeat (PHASE_ITEMS) send_random();
        end
        start <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
